/* src/svpd_pkg.sv */
// shared constants for the space vector pwm duty pipeline
`timescale 1ns / 1ps

package svpd_pkg;

	localparam int IN_W    = 16;
	localparam int BUS_W   = 15;
	localparam int DUTY_W  = 16;
	localparam int CODE_W  = 3;
	localparam int PROD_W  = 48;
	localparam int NUM_W   = 47;
	localparam int RESCALE_LOG2 = 38;

	localparam logic [BUS_W-1:0] BUS_RESET = 15'd6144;
	localparam logic signed [31:0] SQRT3_Q30 = 32'sd1859775393;

	typedef logic [CODE_W-1:0] code_t;

	localparam code_t CODE_ZERO_LO = 3'd0;
	localparam code_t CODE_S1      = 3'd1;
	localparam code_t CODE_S2      = 3'd2;
	localparam code_t CODE_S3      = 3'd3;
	localparam code_t CODE_S4      = 3'd4;
	localparam code_t CODE_S5      = 3'd5;
	localparam code_t CODE_S6      = 3'd6;
	localparam code_t CODE_ZERO_HI = 3'd7;

endpackage

/* src/svpd_front.sv */
// sector sign tests and selection of the two active-time numerators
`timescale 1ns / 1ps

module svpd_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          in_vld,
	input  logic signed [svpd_pkg::IN_W-1:0] alpha,
	input  logic signed [svpd_pkg::IN_W-1:0] beta,
	output logic                          out_vld,
	output logic [svpd_pkg::NUM_W-1:0]    n0,
	output logic [svpd_pkg::NUM_W-1:0]    n1,
	output svpd_pkg::code_t               code
);

	localparam int PW = svpd_pkg::PROD_W;

	logic                 vld_s1, vld_s2;
	logic signed [PW-1:0] x_s1, bs_s1;
	logic [svpd_pkg::NUM_W-1:0] n0_s2, n1_s2;
	svpd_pkg::code_t      code_s2;

	logic signed [PW-1:0] ua, ub, uc, d1, d2, sel0, sel1;
	svpd_pkg::code_t      code_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1  <= PW'(alpha) * PW'(svpd_pkg::SQRT3_Q30);
			bs_s1 <= $signed({{(PW-svpd_pkg::IN_W-30){beta[svpd_pkg::IN_W-1]}}, beta, 30'b0});
		end
	end

	always_comb begin
		ua = bs_s1 <<< 1;
		ub = x_s1 + bs_s1;
		uc = bs_s1 - x_s1;
		d1 = x_s1 - bs_s1;
		d2 = -x_s1 - bs_s1;
		code_c = {~d2[PW-1], ~d1[PW-1], ~bs_s1[PW-1]};
		unique case (code_c)
			svpd_pkg::CODE_S1: begin sel0 = uc;  sel1 = ub;  end
			svpd_pkg::CODE_S2: begin sel0 = ub;  sel1 = -ua; end
			svpd_pkg::CODE_S3: begin sel0 = -uc; sel1 = ua;  end
			svpd_pkg::CODE_S4: begin sel0 = -ua; sel1 = uc;  end
			svpd_pkg::CODE_S5: begin sel0 = ua;  sel1 = -ub; end
			svpd_pkg::CODE_S6: begin sel0 = -ub; sel1 = -uc; end
			default: begin sel0 = '0; sel1 = '0; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// negative numerators clamp to zero
			n0_s2   <= sel0[PW-1] ? '0 : sel0[svpd_pkg::NUM_W-1:0];
			n1_s2   <= sel1[PW-1] ? '0 : sel1[svpd_pkg::NUM_W-1:0];
			code_s2 <= code_c;
		end
	end

	assign out_vld = vld_s2;
	assign n0      = n0_s2;
	assign n1      = n1_s2;
	assign code    = code_s2;

endmodule

/* src/svpd_div.sv */
// two-lane pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps

module svpd_div #(
	parameter int NW = 47,
	parameter int DW = 31,
	parameter int QW = 32,
	parameter int SW = 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          in_vld,
	input  logic [NW-1:0] num0,
	input  logic [NW-1:0] num1,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side_in,
	output logic          out_vld,
	output logic [QW-1:0] quo0,
	output logic [QW-1:0] quo1,
	output logic [SW-1:0] side_out
);

	logic          vld_s  [QW];
	logic [DW-1:0] rem0_s [QW];
	logic [DW-1:0] rem1_s [QW];
	logic [QW-1:0] low0_s [QW];
	logic [QW-1:0] low1_s [QW];
	logic [QW-1:0] quo0_s [QW];
	logic [QW-1:0] quo1_s [QW];
	logic [DW-1:0] den_s  [QW];
	logic [SW-1:0] side_s [QW];

	for (genvar i = 0; i < QW; i++) begin : g_stage
		logic          v_in;
		logic [DW-1:0] r0_in, r1_in, d_in;
		logic [QW-1:0] l0_in, l1_in, q0_in, q1_in;
		logic [SW-1:0] sd_in;
		logic [DW:0]   tr0, tr1;
		logic          ge0, ge1;

		if (i == 0) begin : g_head
			// top bits are below the divisor, so the first remainder fits
			assign v_in  = in_vld;
			assign r0_in = DW'(num0[NW-1:QW]);
			assign r1_in = DW'(num1[NW-1:QW]);
			assign l0_in = num0[QW-1:0];
			assign l1_in = num1[QW-1:0];
			assign q0_in = '0;
			assign q1_in = '0;
			assign d_in  = den;
			assign sd_in = side_in;
		end else begin : g_body
			assign v_in  = vld_s[i-1];
			assign r0_in = rem0_s[i-1];
			assign r1_in = rem1_s[i-1];
			assign l0_in = low0_s[i-1];
			assign l1_in = low1_s[i-1];
			assign q0_in = quo0_s[i-1];
			assign q1_in = quo1_s[i-1];
			assign d_in  = den_s[i-1];
			assign sd_in = side_s[i-1];
		end

		assign tr0 = {r0_in, l0_in[QW-1-i]};
		assign tr1 = {r1_in, l1_in[QW-1-i]};
		assign ge0 = tr0 >= {1'b0, d_in};
		assign ge1 = tr1 >= {1'b0, d_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (adv) begin
				vld_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem0_s[i] <= ge0 ? DW'(tr0 - {1'b0, d_in}) : DW'(tr0);
				rem1_s[i] <= ge1 ? DW'(tr1 - {1'b0, d_in}) : DW'(tr1);
				low0_s[i] <= l0_in;
				low1_s[i] <= l1_in;
				quo0_s[i] <= {q0_in[QW-2:0], ge0};
				quo1_s[i] <= {q1_in[QW-2:0], ge1};
				den_s[i]  <= d_in;
				side_s[i] <= sd_in;
			end
		end
	end

	assign out_vld  = vld_s[QW-1];
	assign quo0     = quo0_s[QW-1];
	assign quo1     = quo1_s[QW-1];
	assign side_out = side_s[QW-1];

endmodule

/* src/svpd_scale.sv */
// overmodulation test and pre-shift of the times ahead of rescaling
`timescale 1ns / 1ps

module svpd_scale #(
	parameter int F  = 15,
	parameter int TW = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            in_vld,
	input  logic [TW-1:0]   t0,
	input  logic [TW-1:0]   t1,
	input  svpd_pkg::code_t code_in,
	output logic            out_vld,
	output logic [TW-1:0]   t0s,
	output logic [TW-1:0]   t1s,
	output logic [TW:0]     sum,
	output logic [F:0]      t0f,
	output logic [F:0]      t1f,
	output logic            over,
	output svpd_pkg::code_t code_out
);

	localparam int KMAX = (TW + 1 > svpd_pkg::RESCALE_LOG2) ?
		TW + 1 - svpd_pkg::RESCALE_LOG2 : 0;
	localparam logic [TW:0] ONE = (TW+1)'(1) << F;

	logic            vld_s1, over_s1;
	logic [TW-1:0]   t0s_s1, t1s_s1;
	logic [TW:0]     sum_s1;
	logic [F:0]      t0f_s1, t1f_s1;
	svpd_pkg::code_t code_s1;

	logic [TW:0]   s_raw, s_k, s_sel;
	logic [TW-1:0] a_sel, b_sel;

	always_comb begin
		s_raw = (TW+1)'(t0) + (TW+1)'(t1);
		a_sel = t0;
		b_sel = t1;
		s_sel = s_raw;
		s_k   = s_raw;
		// smallest common shift that brings the sum below the limit
		for (int k = KMAX; k >= 0; k--) begin
			s_k = (TW+1)'(t0 >> k) + (TW+1)'(t1 >> k);
			if ((s_k >> svpd_pkg::RESCALE_LOG2) == '0) begin
				a_sel = t0 >> k;
				b_sel = t1 >> k;
				s_sel = s_k;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			over_s1 <= s_raw > ONE;
			t0s_s1  <= a_sel;
			t1s_s1  <= b_sel;
			sum_s1  <= s_sel;
			t0f_s1  <= t0[F:0];
			t1f_s1  <= t1[F:0];
			code_s1 <= code_in;
		end
	end

	assign out_vld  = vld_s1;
	assign t0s      = t0s_s1;
	assign t1s      = t1s_s1;
	assign sum      = sum_s1;
	assign t0f      = t0f_s1;
	assign t1f      = t1f_s1;
	assign over     = over_s1;
	assign code_out = code_s1;

endmodule

/* src/svpd_duty.sv */
// zero-vector share, switching levels and phase assignment by sector
`timescale 1ns / 1ps

module svpd_duty #(
	parameter int F = 15
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          in_vld,
	input  logic [F:0]                    t0f,
	input  logic [F:0]                    t1f,
	input  logic [F:0]                    q0,
	input  logic [F:0]                    q1,
	input  logic                          over,
	input  svpd_pkg::code_t               code,
	output logic                          out_vld,
	output logic [svpd_pkg::DUTY_W-1:0]   da,
	output logic [svpd_pkg::DUTY_W-1:0]   db,
	output logic [svpd_pkg::DUTY_W-1:0]   dc,
	output svpd_pkg::code_t               code_out,
	output logic                          over_out
);

	localparam int LW = F + 2;
	localparam logic [LW-1:0] ONE = LW'(1) << F;

	logic                        vld_s1, over_s1;
	logic [svpd_pkg::DUTY_W-1:0] da_s1, db_s1, dc_s1;
	svpd_pkg::code_t             code_s1;

	logic [LW-1:0] tt0, tt1, z, la, lb, lc, pa, pb, pc;
	logic          zero_vec;

	always_comb begin
		tt0 = over ? LW'(q0) : LW'(t0f);
		tt1 = over ? LW'(q1) : LW'(t1f);
		z   = (ONE - tt0 - tt1) >> 1;
		la  = z;
		lb  = z + tt0;
		lc  = lb + tt1;
		zero_vec = (code == svpd_pkg::CODE_ZERO_LO) || (code == svpd_pkg::CODE_ZERO_HI);
		unique case (code)
			svpd_pkg::CODE_S1: begin pa = lb; pb = la; pc = lc; end
			svpd_pkg::CODE_S2: begin pa = la; pb = lc; pc = lb; end
			svpd_pkg::CODE_S3: begin pa = la; pb = lb; pc = lc; end
			svpd_pkg::CODE_S4: begin pa = lc; pb = lb; pc = la; end
			svpd_pkg::CODE_S5: begin pa = lc; pb = la; pc = lb; end
			svpd_pkg::CODE_S6: begin pa = lb; pb = lc; pc = la; end
			default:           begin pa = '0; pb = '0; pc = '0; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			da_s1   <= svpd_pkg::DUTY_W'(pa);
			db_s1   <= svpd_pkg::DUTY_W'(pb);
			dc_s1   <= svpd_pkg::DUTY_W'(pc);
			over_s1 <= over && !zero_vec;
			code_s1 <= code;
		end
	end

	assign out_vld  = vld_s1;
	assign da       = da_s1;
	assign db       = db_s1;
	assign dc       = dc_s1;
	assign code_out = code_s1;
	assign over_out = over_s1;

endmodule

/* src/space_vector_pwm_duty.sv */
// top level of the space vector pwm duty generator
//
// Input channel: in_valid / in_ready carry one (alpha_voltage, beta_voltage)
// reference vector per transaction. Output channel: out_valid / out_ready
// carry the three phase duties, the raw sector code and the overmodulation
// flag, one result transaction for every input transaction, in order.
// The bus voltage register is written through cfg_wr_en / cfg_wr_data;
// the user must write it only while no transaction is in flight, as the
// block itself does not enforce this; zero is treated as one.
// Throughput is one vector per cycle while the output is not stalled.
// The pipeline holds two bit-per-stage dividers: one for the active
// times, one for the rescale to a full period.
// When out_ready is low with a result waiting the whole pipeline holds,
// in_ready drops and nothing is lost or repeated.
// Reset clears every stage valid bit and loads the bus voltage with 6144
// (24 V); no clearing pass is needed afterwards.
`timescale 1ns / 1ps

module space_vector_pwm_duty #(
	parameter int DUTY_FRAC_BITS = 15
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [svpd_pkg::IN_W-1:0]  alpha_voltage,
	input  logic signed [svpd_pkg::IN_W-1:0]  beta_voltage,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [svpd_pkg::DUTY_W-1:0]       duty_a,
	output logic [svpd_pkg::DUTY_W-1:0]       duty_b,
	output logic [svpd_pkg::DUTY_W-1:0]       duty_c,
	output logic [svpd_pkg::CODE_W-1:0]       sector_code,
	output logic                              overmodulated,
	input  logic                              cfg_wr_en,
	input  logic [svpd_pkg::BUS_W-1:0]        cfg_wr_data
);

	localparam int F   = DUTY_FRAC_BITS;
	localparam int SH  = 31 - F;
	localparam int TW  = svpd_pkg::NUM_W - SH;
	localparam int DW1 = svpd_pkg::BUS_W + SH;
	localparam int NW2 = TW + F;
	localparam int SW2 = svpd_pkg::CODE_W + 1 + 2 * (F + 1);

	logic                       adv;
	logic [svpd_pkg::BUS_W-1:0] bus_q, udc;

	logic                       f_vld;
	logic [svpd_pkg::NUM_W-1:0] f_n0, f_n1;
	svpd_pkg::code_t            f_code;

	logic                       d1_vld;
	logic [TW-1:0]              d1_t0, d1_t1;
	svpd_pkg::code_t            d1_code;

	logic                       sc_vld, sc_over;
	logic [TW-1:0]              sc_t0s, sc_t1s;
	logic [TW:0]                sc_sum;
	logic [F:0]                 sc_t0f, sc_t1f;
	svpd_pkg::code_t            sc_code;

	logic                       d2_vld;
	logic [F:0]                 d2_q0, d2_q1;
	logic [SW2-1:0]             d2_side;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_q <= svpd_pkg::BUS_RESET;
		end else if (cfg_wr_en) begin
			bus_q <= cfg_wr_data;
		end
	end

	assign udc      = (bus_q == '0) ? svpd_pkg::BUS_W'(1) : bus_q;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	svpd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (in_valid),
		.alpha   (alpha_voltage),
		.beta    (beta_voltage),
		.out_vld (f_vld),
		.n0      (f_n0),
		.n1      (f_n1),
		.code    (f_code)
	);

	// floor(n / (udc * 2^SH)) gives the time with F fraction bits
	svpd_div #(
		.NW (svpd_pkg::NUM_W),
		.DW (DW1),
		.QW (TW),
		.SW (svpd_pkg::CODE_W)
	) u_div_time (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (f_vld),
		.num0     (f_n0),
		.num1     (f_n1),
		.den      (DW1'(udc) << SH),
		.side_in  (f_code),
		.out_vld  (d1_vld),
		.quo0     (d1_t0),
		.quo1     (d1_t1),
		.side_out (d1_code)
	);

	svpd_scale #(
		.F  (F),
		.TW (TW)
	) u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (d1_vld),
		.t0       (d1_t0),
		.t1       (d1_t1),
		.code_in  (d1_code),
		.out_vld  (sc_vld),
		.t0s      (sc_t0s),
		.t1s      (sc_t1s),
		.sum      (sc_sum),
		.t0f      (sc_t0f),
		.t1f      (sc_t1f),
		.over     (sc_over),
		.code_out (sc_code)
	);

	// t * 2^F / sum, used only when the flag is set
	svpd_div #(
		.NW (NW2),
		.DW (TW + 1),
		.QW (F + 1),
		.SW (SW2)
	) u_div_rescale (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (sc_vld),
		.num0     ({sc_t0s, {F{1'b0}}}),
		.num1     ({sc_t1s, {F{1'b0}}}),
		.den      (sc_sum),
		.side_in  ({sc_code, sc_over, sc_t0f, sc_t1f}),
		.out_vld  (d2_vld),
		.quo0     (d2_q0),
		.quo1     (d2_q1),
		.side_out (d2_side)
	);

	svpd_duty #(
		.F (F)
	) u_duty (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (d2_vld),
		.t0f      (d2_side[2*(F+1)-1:F+1]),
		.t1f      (d2_side[F:0]),
		.q0       (d2_q0),
		.q1       (d2_q1),
		.over     (d2_side[2*(F+1)]),
		.code     (d2_side[SW2-1:SW2-svpd_pkg::CODE_W]),
		.out_vld  (out_valid),
		.da       (duty_a),
		.db       (duty_b),
		.dc       (duty_c),
		.code_out (sector_code),
		.over_out (overmodulated)
	);

	a_zero_vec_duty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (sector_code == svpd_pkg::CODE_ZERO_LO ||
			sector_code == svpd_pkg::CODE_ZERO_HI)
		|-> duty_a == '0 && duty_b == '0 && duty_c == '0 && !overmodulated)
		else $error("zero vector gave nonzero duty or flag");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(duty_a) &&
			$stable(sector_code) && $stable(overmodulated))
		else $error("stalled result changed");

	a_ready_follows_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready out of step with output side");

endmodule

/* tb/sv/space_vector_pwm_duty_tb.sv */
// self-checking testbench for the space vector pwm duty generator
`timescale 1ns / 1ps

class duty_scoreboard;
	typedef struct {
		logic [15:0] duty_a;
		logic [15:0] duty_b;
		logic [15:0] duty_c;
		logic [2:0]  sector_code;
		logic        overmodulated;
	} duty_result_t;

	duty_result_t expected_duties[$];
	int unsigned   bus_voltage;
	int            frac_bits;
	int            fails;

	function new(int f);
		frac_bits   = f;
		bus_voltage = 32'(svpd_pkg::BUS_RESET);
		fails       = 0;
	endfunction

	function int pending();
		return expected_duties.size();
	endfunction

	// works out the duties for one accepted vector
	function void note_vector(logic signed [15:0] alpha, logic signed [15:0] beta);
		longint            av, bv, x, bs, ua, ub, uc, n0, n1;
		longint unsigned   udc, one, t0, t1, s, z, la, lb, lc;
		svpd_pkg::code_t   code;
		duty_result_t      r;
		av = alpha;
		bv = beta;
		x = av * longint'(svpd_pkg::SQRT3_Q30);
		bs = bv * (64'sd1 <<< 30);
		ua = 2 * bs;
		ub = x + bs;
		uc = -x + bs;
		code = '0;
		code[0] = (bv >= 0);
		code[1] = (x - bs >= 0);
		code[2] = (-x - bs >= 0);
		r.sector_code = code;
		r.overmodulated = 1'b0;
		r.duty_a = '0;
		r.duty_b = '0;
		r.duty_c = '0;
		n0 = 0;
		n1 = 0;
		case (code)
			svpd_pkg::CODE_S1: begin n0 = uc;  n1 = ub;  end
			svpd_pkg::CODE_S2: begin n0 = ub;  n1 = -ua; end
			svpd_pkg::CODE_S3: begin n0 = -uc; n1 = ua;  end
			svpd_pkg::CODE_S4: begin n0 = -ua; n1 = uc;  end
			svpd_pkg::CODE_S5: begin n0 = ua;  n1 = -ub; end
			svpd_pkg::CODE_S6: begin n0 = -ub; n1 = -uc; end
			default: ;
		endcase
		if (code != svpd_pkg::CODE_ZERO_LO && code != svpd_pkg::CODE_ZERO_HI) begin
			if (n0 < 0) n0 = 0;
			if (n1 < 0) n1 = 0;
			udc = (bus_voltage == 0) ? 64'd1 : 64'(bus_voltage);
			one = 64'd1 << frac_bits;
			t0 = (longint'(unsigned'(n0)) / udc) >> (31 - frac_bits);
			t1 = (longint'(unsigned'(n1)) / udc) >> (31 - frac_bits);
			s = t0 + t1;
			if (s > one) begin
				r.overmodulated = 1'b1;
				while (s >= (64'd1 << svpd_pkg::RESCALE_LOG2)) begin
					t0 = t0 >> 1;
					t1 = t1 >> 1;
					s = t0 + t1;
				end
				if (s == 0) s = 1;
				t0 = t0 * one / s;
				t1 = t1 * one / s;
			end
			z = (one - t0 - t1) >> 1;
			la = z;
			lb = z + t0;
			lc = lb + t1;
			case (code)
				svpd_pkg::CODE_S1: begin
					r.duty_a = 16'(lb); r.duty_b = 16'(la); r.duty_c = 16'(lc);
				end
				svpd_pkg::CODE_S2: begin
					r.duty_a = 16'(la); r.duty_b = 16'(lc); r.duty_c = 16'(lb);
				end
				svpd_pkg::CODE_S3: begin
					r.duty_a = 16'(la); r.duty_b = 16'(lb); r.duty_c = 16'(lc);
				end
				svpd_pkg::CODE_S4: begin
					r.duty_a = 16'(lc); r.duty_b = 16'(lb); r.duty_c = 16'(la);
				end
				svpd_pkg::CODE_S5: begin
					r.duty_a = 16'(lc); r.duty_b = 16'(la); r.duty_c = 16'(lb);
				end
				default: begin
					r.duty_a = 16'(lb); r.duty_b = 16'(lc); r.duty_c = 16'(la);
				end
			endcase
		end
		expected_duties.push_back(r);
	endfunction

	function void compare_field(string name, longint unsigned exp_v, longint unsigned act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
			fails++;
		end
	endfunction

	function void check_result(duty_result_t act);
		duty_result_t e;
		if (expected_duties.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual duties %0d %0d %0d",
				$time, act.duty_a, act.duty_b, act.duty_c);
			fails++;
			return;
		end
		e = expected_duties.pop_front();
		compare_field("duty_a", e.duty_a, act.duty_a);
		compare_field("duty_b", e.duty_b, act.duty_b);
		compare_field("duty_c", e.duty_c, act.duty_c);
		compare_field("sector_code", e.sector_code, act.sector_code);
		compare_field("overmodulated", e.overmodulated, act.overmodulated);
	endfunction
endclass

module space_vector_pwm_duty_tb;
	localparam int FRAC       = 15;
	localparam int LATENCY    = 2 + (16 + FRAC) + 1 + (FRAC + 1) + 1;
	localparam int IDLE_LIMIT = 20000;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic signed [15:0] alpha_voltage;
	logic signed [15:0] beta_voltage;
	logic              out_valid;
	logic              out_ready;
	logic [15:0]       duty_a;
	logic [15:0]       duty_b;
	logic [15:0]       duty_c;
	logic [2:0]        sector_code;
	logic              overmodulated;
	logic              cfg_wr_en;
	logic [14:0]       cfg_wr_data;

	duty_scoreboard sb;
	int  vectors_sent;
	bit  hold_request;
	int  idle_cycles;

	space_vector_pwm_duty #(.DUTY_FRAC_BITS(FRAC)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.alpha_voltage(alpha_voltage), .beta_voltage(beta_voltage),
		.out_valid(out_valid), .out_ready(out_ready),
		.duty_a(duty_a), .duty_b(duty_b), .duty_c(duty_c),
		.sector_code(sector_code), .overmodulated(overmodulated),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		sb = new(FRAC);
		arst_n = 1'b0;
		in_valid = 1'b0;
		alpha_voltage = '0;
		beta_voltage = '0;
		out_ready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		vectors_sent = 0;
		hold_request = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
	end

	// result monitor and no-progress watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result('{duty_a, duty_b, duty_c, sector_code, overmodulated});
			if ((out_valid && out_ready) || (in_valid && in_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end else begin
			idle_cycles <= 0;
		end
	end

	// receiver: stall pattern changes every stretch, one long hold-off on request
	initial begin
		int mode;
		int i;
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				@(negedge clk) out_ready <= 1'b0;
				repeat (400) @(negedge clk);
			end
			mode = $urandom_range(0, 3);
			for (i = 0; i < 64; i++) begin
				@(negedge clk);
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= ($urandom_range(0, 7) != 0);
					default: out_ready <= ((i % 16) < 5);
				endcase
			end
		end
	end

	task automatic send_vector(logic signed [15:0] a, logic signed [15:0] b);
		@(negedge clk);
		in_valid <= 1'b1;
		alpha_voltage <= a;
		beta_voltage <= b;
		do @(posedge clk); while (!in_ready);
		sb.note_vector(a, b);
		vectors_sent++;
		if (vectors_sent == 300) hold_request = 1'b1;
	endtask

	task automatic pause_sender(int cycles);
		@(negedge clk) in_valid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	task automatic drain_and_write_bus(logic [14:0] v);
		pause_sender(0);
		while (sb.pending() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk) cfg_wr_en <= 1'b0;
		sb.bus_voltage = 32'(v);
	endtask

	function automatic logic signed [15:0] random_voltage();
		int span;
		span = (sb.bus_voltage < 64) ? 64 : int'(sb.bus_voltage);
		if (span > 32767) span = 32767;
		case ($urandom_range(0, 4))
			0: return 16'($urandom);
			1: return 16'(int'($urandom_range(0, 1023)) - 512);
			2: return 16'(int'($urandom_range(0, 2 * span)) - span);
			3: return 16'(int'($urandom_range(0, span)) - span / 2);
			default: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
		endcase
	endfunction

	task automatic random_vectors(int n);
		int left;
		int burst;
		left = n;
		while (left > 0) begin
			burst = $urandom_range(1, 24);
			if (burst > left) burst = left;
			repeat (burst) send_vector(random_voltage(), random_voltage());
			left -= burst;
			if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 6));
		end
	endtask

	initial begin
		logic [14:0] bus_settings[6];
		int k;
		bus_settings = '{15'd256, 15'd32767, 15'd0, 15'd1, 15'd6144, 15'd3000};
		@(posedge arst_n);
		// extremes, zero vector and unit steps
		send_vector(16'sh7fff, 16'sh0000);
		send_vector(16'sh8000, 16'sh0000);
		send_vector(16'sh0000, 16'sh7fff);
		send_vector(16'sh0000, 16'sh8000);
		send_vector(16'sh7fff, 16'sh7fff);
		send_vector(16'sh8000, 16'sh8000);
		send_vector(16'sh7fff, 16'sh8000);
		send_vector(16'sh8000, 16'sh7fff);
		send_vector(0, 0);
		send_vector(1, 0);
		send_vector(-1, 0);
		send_vector(0, 1);
		send_vector(0, -1);
		// one vector in each sector
		send_vector(1000, 577);
		send_vector(0, 1000);
		send_vector(-1000, 577);
		send_vector(-1000, -577);
		send_vector(0, -1000);
		send_vector(1000, -577);
		// near the diagonal sector borders
		send_vector(1, 1);
		send_vector(1, 2);
		send_vector(-1, 2);
		send_vector(300, 520);
		send_vector(-300, -520);
		random_vectors(200);
		for (k = 0; k < 6; k++) begin
			drain_and_write_bus(k == 5 ? 15'($urandom_range(256, 32767)) : bus_settings[k]);
			random_vectors(140);
		end
		pause_sender(0);
		while (sb.pending() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (sb.fails == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
